// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants for the LRU key-value cache: field layout, request kinds
// and configuration register indexes.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int FIELD_W     = 32;

    // input transfer: tuser = req_type, tdata = {write_value, lookup_key}
    localparam int IN_KEY_LSB  = 0;
    localparam int IN_VAL_LSB  = 32;
    localparam int IN_TDATA_W  = 64;

    // output transfer: tdata = {pad, evicted_key, evicted, read_value, hit}
    localparam int OUT_HIT_BIT   = 0;
    localparam int OUT_RVAL_LSB  = 1;
    localparam int OUT_EV_BIT    = 33;
    localparam int OUT_EVKEY_LSB = 34;
    localparam int OUT_USED_W    = 66;
    localparam int OUT_TDATA_W   = 72;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LRU_MODE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with a recency order and eviction of the
// back entry on a new-key insert when the configured capacity is reached.
//
//   channel   dir  handshake                     payload
//   s_axis    in   tvalid/tready                 tuser: req_type
//                                                tdata: lookup_key, write_value
//   m_axis    out  tvalid/tready                 tdata: hit, read_value,
//                                                       evicted, evicted_key
//   cfg       in   i_cfg_we (no wait)            i_cfg_addr, i_cfg_wdata
//
// One request per cycle sustained while m_axis is not stalled; a result
// passes from its transfer on s_axis through the input register, then the
// result register, before it shows on m_axis.
// The key compare over all slots and the rank update run combinationally
// between the input register and the result register, so state is current
// for the request that follows directly.
// A stalled m_axis holds the result register; s_axis_tready drops in the same
// cycle once the input register holds a request, else after one more transfer.
// Synchronous active-low reset empties the cache and restores capacity 16 and
// LRU mode.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES     = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lkvc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lkvc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // lookup_key, write_value
    input  logic [0:0]                          s_axis_tuser,  // req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lkvc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // hit, read_value, evicted,
                                                               // evicted_key, zero pad
);
    import lkvc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int KEXT_W = (KEY_WIDTH > FIELD_W) ? KEY_WIDTH : FIELD_W;
    localparam int VEXT_W = (VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W;

    // configuration
    logic [CFG_DATA_W-1:0]  r_capacity;
    logic                   r_lru_mode;

    // slot store
    logic [KEY_WIDTH-1:0]   r_slot_key   [ENTRIES];
    logic [VALUE_WIDTH-1:0] r_slot_value [ENTRIES];
    logic [ENTRIES-1:0]     r_slot_valid, n_slot_valid;
    logic [IDX_W-1:0]       r_slot_rank  [ENTRIES];
    logic [IDX_W-1:0]       n_slot_rank  [ENTRIES];
    logic [CNT_W-1:0]       r_occ, n_occ;

    // input register
    logic                   r_in_valid;
    logic                   r_in_req;
    logic [KEY_WIDTH-1:0]   r_in_key;
    logic [VALUE_WIDTH-1:0] r_in_val;

    // result register
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [FIELD_W-1:0]     r_out_rval;
    logic                   r_out_ev;
    logic [FIELD_W-1:0]     r_out_evkey;

    logic                   w_adv;
    logic [KEXT_W-1:0]      w_in_key_ext;
    logic [VEXT_W-1:0]      w_in_val_ext;

    logic [ENTRIES-1:0]     w_match;
    logic                   w_hit;
    logic [IDX_W-1:0]       w_hit_idx;
    logic [IDX_W-1:0]       w_hit_rank;
    logic [VALUE_WIDTH-1:0] w_hit_val;
    logic [CMP_W-1:0]       w_eff_cap;
    logic                   w_full;
    logic [CNT_W-1:0]       w_back;
    logic                   w_back_found;
    logic [IDX_W-1:0]       w_back_idx;
    logic                   w_free_found;
    logic [IDX_W-1:0]       w_free_idx;
    logic                   w_evict;
    logic                   w_place;
    logic [IDX_W-1:0]       w_target;
    logic [CNT_W-1:0]       w_limit;
    logic                   w_update;
    logic [KEY_WIDTH-1:0]   w_ev_key;
    logic [KEXT_W-1:0]      w_ev_key_ext;
    logic [VEXT_W-1:0]      w_rval_ext;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_in_key_ext = KEXT_W'(s_axis_tdata[IN_KEY_LSB +: FIELD_W]);
    assign w_in_val_ext = VEXT_W'(s_axis_tdata[IN_VAL_LSB +: FIELD_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
            r_lru_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CAPACITY: r_capacity <= i_cfg_wdata;
                CFG_LRU_MODE: r_lru_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req <= s_axis_tuser[0];
            r_in_key <= w_in_key_ext[KEY_WIDTH-1:0];
            r_in_val <= w_in_val_ext[VALUE_WIDTH-1:0];
        end
    end

    // associative search
    always_comb begin
        w_hit_idx    = '0;
        w_hit_rank   = '0;
        w_hit_val    = '0;
        w_back_found = 1'b0;
        w_back_idx   = '0;
        w_free_found = 1'b0;
        w_free_idx   = '0;
        w_ev_key     = '0;
        w_back       = r_occ - CNT_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_slot_valid[i] && (r_slot_key[i] == r_in_key);
            if (w_match[i]) begin
                w_hit_idx  = w_hit_idx | IDX_W'(i);
                w_hit_rank = w_hit_rank | r_slot_rank[i];
                w_hit_val  = w_hit_val | r_slot_value[i];
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_slot_valid[i] && (CNT_W'(r_slot_rank[i]) == w_back)) begin
                w_back_found = 1'b1;
                w_back_idx   = IDX_W'(i);
                w_ev_key     = r_slot_key[i];
            end
            if (!r_slot_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_W'(i);
            end
        end
        w_hit = |w_match;
    end

    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_capacity) > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_capacity);
        end
        w_full   = (CMP_W'(r_occ) >= w_eff_cap) && (r_occ != '0);
        w_evict  = (r_in_req == REQ_INSERT) && !w_hit && w_full && w_back_found;
        w_place  = (r_in_req == REQ_INSERT) && !w_hit && (w_evict || w_free_found);
        w_target = w_evict ? w_back_idx : w_free_idx;
        w_limit  = w_evict ? w_back : r_occ;
        w_update = (r_in_req == REQ_INSERT) && w_hit;
    end

    // rank and occupancy update
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_occ        = r_occ;
        for (int i = 0; i < ENTRIES; i++) begin
            n_slot_rank[i] = r_slot_rank[i];
        end
        if (w_adv) begin
            if ((r_in_req == REQ_LOOKUP) && w_hit && r_lru_mode) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_slot_valid[i] && (r_slot_rank[i] < w_hit_rank)) begin
                        n_slot_rank[i] = r_slot_rank[i] + IDX_W'(1);
                    end
                    if (IDX_W'(i) == w_hit_idx) begin
                        n_slot_rank[i] = '0;
                    end
                end
            end
            if (w_place) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_slot_valid[i] && (CNT_W'(r_slot_rank[i]) < w_limit)) begin
                        n_slot_rank[i] = r_slot_rank[i] + IDX_W'(1);
                    end
                    if (IDX_W'(i) == w_target) begin
                        n_slot_rank[i]  = '0;
                        n_slot_valid[i] = 1'b1;
                    end
                end
                if (!w_evict) begin
                    n_occ = r_occ + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_occ        <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_slot_rank[i] <= '0;
            end
        end else begin
            r_slot_valid <= n_slot_valid;
            r_occ        <= n_occ;
            for (int i = 0; i < ENTRIES; i++) begin
                r_slot_rank[i] <= n_slot_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_place) begin
            r_slot_key[w_target]   <= r_in_key;
            r_slot_value[w_target] <= r_in_val;
        end else if (w_adv && w_update) begin
            r_slot_value[w_hit_idx] <= r_in_val;
        end
    end

    // result register
    assign w_rval_ext   = VEXT_W'(w_hit_val);
    assign w_ev_key_ext = KEXT_W'(w_ev_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_hit   <= w_hit;
            r_out_rval  <= ((r_in_req == REQ_LOOKUP) && w_hit) ?
                           w_rval_ext[FIELD_W-1:0] : '0;
            r_out_ev    <= w_evict;
            r_out_evkey <= w_evict ? w_ev_key_ext[FIELD_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0),
                            r_out_evkey, r_out_ev, r_out_rval, r_out_hit};

endmodule

// ===== rtl/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks on the result stream of the LRU key-value cache.
// ----------------------------------------------------------------------------
module lkvc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [lkvc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import lkvc_pkg::*;

    // a stalled transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_EV_BIT]) |-> !m_axis_tdata[OUT_HIT_BIT])
        else $error("eviction reported on a hit");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[OUT_HIT_BIT])
            |-> (m_axis_tdata[OUT_RVAL_LSB +: FIELD_W] == '0))
        else $error("value returned on a miss");

    a_evkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[OUT_EV_BIT])
            |-> (m_axis_tdata[OUT_EVKEY_LSB +: FIELD_W] == '0))
        else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
